[rtl/pinned_page_frame_replacement_macros.svh]
// ----------------------------------------------------------------------------
// pinned_page_frame_replacement_macros
// Assertion macros used by the frame manager checker.
// ----------------------------------------------------------------------------
`ifndef PINNED_PAGE_FRAME_REPLACEMENT_MACROS_SVH
`define PINNED_PAGE_FRAME_REPLACEMENT_MACROS_SVH

// property must hold at every clock edge out of reset
`define PPFR_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("frame manager assertion failed");

// condition must never be seen out of reset
`define PPFR_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("frame manager forbidden condition seen");

`endif

[rtl/ppfr_pkg.sv]
// ----------------------------------------------------------------------------
// ppfr_pkg
// Types and constants of the pinned page frame manager.
// ----------------------------------------------------------------------------
package ppfr_pkg;

	localparam int IDX_W  = 6;
	localparam int PAGE_W = 16;
	localparam int PIN_W  = 8;
	localparam int CNT_W  = 32;
	localparam int OP_W   = 3;
	localparam int QIDX_W = 4;
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;
	localparam int FIU_W  = 5;

	typedef logic [IDX_W-1:0] fidx_t;
	typedef logic [IDX_W:0]   fcnt_t;

	typedef enum logic [OP_W-1:0] {
		OP_PIN       = 3'd0,
		OP_UNPIN     = 3'd1,
		OP_DIRTY     = 3'd2,
		OP_FLUSH     = 3'd3,
		OP_FLUSH_ALL = 3'd4,
		OP_QUERY     = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		PR_NONE,
		PR_PAGE,
		PR_RANK,
		PR_INDEX
	} probe_mode_t;

	typedef struct packed {
		probe_mode_t        mode;
		logic [PAGE_W-1:0]  page;
		fidx_t              key;
	} probe_t;

	typedef struct packed {
		logic               head_en;
		fidx_t              head_rank;
		fidx_t              tgt;
		logic               fill_en;
		logic [PAGE_W-1:0]  fill_page;
		logic               pin_inc;
		logic               pin_dec;
		logic               set_dirty;
		logic               clr_dirty;
	} cmd_t;

	typedef struct packed {
		logic               found;
		fidx_t              fidx;
		fidx_t              rank;
		logic [PIN_W-1:0]   pin;
		logic               dirty;
		logic               valid;
		logic [PAGE_W-1:0]  page;
		logic               later;
	} chain_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_FIND,
		S_FILL_SEL,
		S_EVICT,
		S_FLUSH,
		S_REPORT
	} state_t;

	typedef enum logic [0:0] {
		REG_POLICY = 1'b0,
		REG_FRAMES = 1'b1
	} reg_idx_t;

	localparam logic POLICY_FIFO = 1'b0;
	localparam logic POLICY_LRU  = 1'b1;

endpackage

[rtl/ppfr_if.sv]
// ----------------------------------------------------------------------------
// ppfr_if
// Request and response channels of the frame manager.
// ----------------------------------------------------------------------------
interface ppfr_req_if;
	logic                        valid;
	logic                        ready;
	logic [ppfr_pkg::OP_W-1:0]   opcode;
	logic [ppfr_pkg::PAGE_W-1:0] page_id;
	logic [ppfr_pkg::QIDX_W-1:0] frame_index;

	modport source (output valid, output opcode, output page_id, output frame_index,
		input ready);
	modport sink (input valid, input opcode, input page_id, input frame_index,
		output ready);
endinterface

interface ppfr_rsp_if;
	logic                        valid;
	logic                        ready;
	logic                        status;
	logic                        hit;
	logic [3:0]                  frame;
	logic                        read_fill;
	logic                        writeback;
	logic [ppfr_pkg::PAGE_W-1:0] writeback_page;
	logic [ppfr_pkg::PIN_W-1:0]  pin_count;
	logic                        dirty_flag;
	logic signed [16:0]          frame_page;
	logic                        last_result;
	logic [ppfr_pkg::CNT_W-1:0]  read_total;
	logic [ppfr_pkg::CNT_W-1:0]  write_total;

	modport source (output valid, output status, output hit, output frame,
		output read_fill, output writeback, output writeback_page, output pin_count,
		output dirty_flag, output frame_page, output last_result, output read_total,
		output write_total, input ready);
	modport sink (input valid, input status, input hit, input frame,
		input read_fill, input writeback, input writeback_page, input pin_count,
		input dirty_flag, input frame_page, input last_result, input read_total,
		input write_total, output ready);
endinterface

[rtl/ppfr_cell.sv]
// ----------------------------------------------------------------------------
// ppfr_cell
// One page frame: page, pin count, dirty mark, recency rank, lookup chain link.
// ----------------------------------------------------------------------------
module ppfr_cell #(
	parameter int IDX = 0
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             init,
	input  ppfr_pkg::fcnt_t  fiu,
	input  ppfr_pkg::cmd_t   cmd,
	input  ppfr_pkg::probe_t probe,
	input  ppfr_pkg::chain_t chain_i,
	output ppfr_pkg::chain_t chain_o
);
	localparam ppfr_pkg::fidx_t MY = ppfr_pkg::fidx_t'(IDX);

	logic [ppfr_pkg::PAGE_W-1:0] page_q;
	logic                        valid_q;
	logic [ppfr_pkg::PIN_W-1:0]  pin_q;
	logic                        dirty_q;
	ppfr_pkg::fidx_t             rank_q;
	logic                        active;
	logic                        sel;
	logic                        me;

	assign active = {1'b0, MY} < fiu;
	assign me     = cmd.tgt == MY;

	always_comb begin
		case (probe.mode)
			ppfr_pkg::PR_PAGE:  sel = active && valid_q && (page_q == probe.page);
			ppfr_pkg::PR_RANK:  sel = active && (rank_q == probe.key);
			ppfr_pkg::PR_INDEX: sel = active && (MY == probe.key);
			default:            sel = 1'b0;
		endcase
	end

	always_comb begin
		chain_o = chain_i;
		if (!chain_i.found && sel) begin
			chain_o.found = 1'b1;
			chain_o.fidx  = MY;
			chain_o.rank  = rank_q;
			chain_o.pin   = pin_q;
			chain_o.dirty = dirty_q;
			chain_o.valid = valid_q;
			chain_o.page  = page_q;
		end
		chain_o.later = chain_i.later | (active && valid_q && dirty_q && (rank_q > probe.key));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			pin_q   <= '0;
			dirty_q <= 1'b0;
			rank_q  <= MY;
		end else if (init) begin
			valid_q <= 1'b0;
			pin_q   <= '0;
			dirty_q <= 1'b0;
			rank_q  <= MY;
		end else begin
			if (cmd.head_en && active) begin
				if (me) begin
					rank_q <= '0;
				end else if (rank_q < cmd.head_rank) begin
					rank_q <= rank_q + 1'b1;
				end
			end
			if (me) begin
				if (cmd.fill_en) begin
					valid_q <= 1'b1;
					dirty_q <= 1'b0;
					pin_q   <= ppfr_pkg::PIN_W'(1);
				end
				if (cmd.pin_inc && pin_q != '1) pin_q <= pin_q + 1'b1;
				if (cmd.pin_dec && pin_q != '0) pin_q <= pin_q - 1'b1;
				if (cmd.set_dirty) dirty_q <= 1'b1;
				if (cmd.clr_dirty) dirty_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (me && cmd.fill_en) page_q <= cmd.fill_page;
	end

endmodule

[rtl/ppfr_ctrl.sv]
// ----------------------------------------------------------------------------
// ppfr_ctrl
// Operation sequencer: drives probes and commands along the cell row, keeps
// counters and the response register.
// ----------------------------------------------------------------------------
module ppfr_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             init,
	input  logic             policy,
	input  ppfr_pkg::fcnt_t  fiu,
	input  ppfr_pkg::chain_t ch,
	output ppfr_pkg::probe_t probe,
	output ppfr_pkg::cmd_t   cmd,
	ppfr_req_if.sink         req,
	ppfr_rsp_if.source       rsp
);
	ppfr_pkg::state_t             state_q, state_d;
	ppfr_pkg::op_t                op_q;
	logic [ppfr_pkg::PAGE_W-1:0]  page_q;
	ppfr_pkg::fidx_t              f_q;
	ppfr_pkg::fidx_t              r_q;
	ppfr_pkg::fcnt_t              filled_q;
	logic [ppfr_pkg::CNT_W-1:0]   reads_q, writes_q;
	logic                         hit_q, wb_q, fill_q, st_q, empty_q, last_q;
	logic [ppfr_pkg::PAGE_W-1:0]  wbpage_q;
	logic                         out_valid_q;

	logic filled_lt, rlast, out_free, evict_ok, flush_hit, accept, rep_empty;

	assign filled_lt = filled_q < fiu;
	assign rlast     = {1'b0, r_q} == (fiu - 1'b1);
	assign out_free  = !out_valid_q || rsp.ready;
	assign evict_ok  = ch.found && (ch.pin == '0);
	assign flush_hit = ch.found && ch.valid && ch.dirty;
	assign accept    = req.valid && req.ready;
	assign rep_empty = empty_q || !ch.found;
	assign rsp.valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ppfr_pkg::S_IDLE: begin
				if (accept && req.opcode <= ppfr_pkg::OP_QUERY) state_d = ppfr_pkg::S_FIND;
			end
			ppfr_pkg::S_FIND: begin
				case (op_q)
					ppfr_pkg::OP_PIN: begin
						if (ch.found) state_d = ppfr_pkg::S_REPORT;
						else if (filled_lt) state_d = ppfr_pkg::S_FILL_SEL;
						else state_d = ppfr_pkg::S_EVICT;
					end
					ppfr_pkg::OP_FLUSH_ALL: state_d = ppfr_pkg::S_FLUSH;
					default: state_d = ppfr_pkg::S_REPORT;
				endcase
			end
			ppfr_pkg::S_FILL_SEL: state_d = ppfr_pkg::S_REPORT;
			ppfr_pkg::S_EVICT: begin
				if (evict_ok || r_q == '0) state_d = ppfr_pkg::S_REPORT;
			end
			ppfr_pkg::S_FLUSH: begin
				if (flush_hit) state_d = ppfr_pkg::S_REPORT;
				else if (rlast) state_d = ppfr_pkg::S_IDLE;
			end
			ppfr_pkg::S_REPORT: begin
				if (out_free) begin
					if (op_q == ppfr_pkg::OP_FLUSH_ALL && !last_q) state_d = ppfr_pkg::S_FLUSH;
					else state_d = ppfr_pkg::S_IDLE;
				end
			end
			default: state_d = ppfr_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		req.ready       = state_q == ppfr_pkg::S_IDLE;
		probe.mode      = ppfr_pkg::PR_NONE;
		probe.page      = page_q;
		probe.key       = r_q;
		cmd             = '0;
		cmd.tgt         = ch.fidx;
		cmd.head_rank   = ch.rank;
		cmd.fill_page   = page_q;
		case (state_q)
			ppfr_pkg::S_FIND: begin
				probe.mode = ppfr_pkg::PR_PAGE;
				if (ch.found) begin
					case (op_q)
						ppfr_pkg::OP_PIN: begin
							cmd.pin_inc = 1'b1;
							cmd.head_en = policy == ppfr_pkg::POLICY_LRU;
						end
						ppfr_pkg::OP_UNPIN: cmd.pin_dec   = 1'b1;
						ppfr_pkg::OP_DIRTY: cmd.set_dirty = 1'b1;
						ppfr_pkg::OP_FLUSH: cmd.clr_dirty = ch.dirty;
						default: ;
					endcase
				end
			end
			ppfr_pkg::S_FILL_SEL: begin
				probe.mode  = ppfr_pkg::PR_RANK;
				probe.key   = filled_q[ppfr_pkg::IDX_W-1:0];
				cmd.fill_en = 1'b1;
				cmd.head_en = 1'b1;
			end
			ppfr_pkg::S_EVICT: begin
				probe.mode  = ppfr_pkg::PR_RANK;
				cmd.fill_en = evict_ok;
				cmd.head_en = evict_ok;
			end
			ppfr_pkg::S_FLUSH: begin
				probe.mode    = ppfr_pkg::PR_RANK;
				cmd.clr_dirty = flush_hit;
			end
			ppfr_pkg::S_REPORT: begin
				probe.mode = ppfr_pkg::PR_INDEX;
				probe.key  = f_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ppfr_pkg::S_IDLE;
			out_valid_q <= 1'b0;
			filled_q    <= '0;
			reads_q     <= '0;
			writes_q    <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ppfr_pkg::S_REPORT && out_free) out_valid_q <= 1'b1;
			else if (rsp.ready) out_valid_q <= 1'b0;
			if (init) begin
				filled_q <= '0;
				reads_q  <= '0;
				writes_q <= '0;
			end else begin
				case (state_q)
					ppfr_pkg::S_FIND: begin
						if (op_q == ppfr_pkg::OP_FLUSH && ch.found && ch.dirty)
							writes_q <= writes_q + 1'b1;
					end
					ppfr_pkg::S_FILL_SEL: begin
						filled_q <= filled_q + 1'b1;
						reads_q  <= reads_q + 1'b1;
						if (ch.valid && ch.dirty) writes_q <= writes_q + 1'b1;
					end
					ppfr_pkg::S_EVICT: begin
						if (evict_ok) begin
							reads_q <= reads_q + 1'b1;
							if (ch.valid && ch.dirty) writes_q <= writes_q + 1'b1;
						end
					end
					ppfr_pkg::S_FLUSH: begin
						if (flush_hit) writes_q <= writes_q + 1'b1;
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ppfr_pkg::S_IDLE: begin
				if (accept) begin
					op_q    <= ppfr_pkg::op_t'(req.opcode);
					page_q  <= req.page_id;
					f_q     <= ppfr_pkg::fidx_t'(req.frame_index);
					hit_q   <= 1'b0;
					wb_q    <= 1'b0;
					fill_q  <= 1'b0;
					st_q    <= 1'b0;
					empty_q <= 1'b0;
					last_q  <= 1'b1;
					wbpage_q <= '0;
				end
			end
			ppfr_pkg::S_FIND: begin
				if (op_q != ppfr_pkg::OP_QUERY) begin
					f_q     <= ch.fidx;
					empty_q <= !ch.found;
				end
				if (op_q == ppfr_pkg::OP_PIN && ch.found) hit_q <= 1'b1;
				if (op_q == ppfr_pkg::OP_FLUSH && ch.found && ch.dirty) begin
					wb_q     <= 1'b1;
					wbpage_q <= ch.page;
				end
				if (op_q == ppfr_pkg::OP_FLUSH_ALL) r_q <= '0;
				else r_q <= ppfr_pkg::IDX_W'(fiu - 1'b1);
			end
			ppfr_pkg::S_FILL_SEL: begin
				f_q      <= ch.fidx;
				empty_q  <= 1'b0;
				fill_q   <= 1'b1;
				wb_q     <= ch.valid && ch.dirty;
				wbpage_q <= ch.page;
			end
			ppfr_pkg::S_EVICT: begin
				if (evict_ok) begin
					f_q      <= ch.fidx;
					empty_q  <= 1'b0;
					fill_q   <= 1'b1;
					wb_q     <= ch.valid && ch.dirty;
					wbpage_q <= ch.page;
				end else if (r_q == '0) begin
					st_q    <= 1'b1;
					empty_q <= 1'b1;
					f_q     <= '0;
				end else begin
					r_q <= r_q - 1'b1;
				end
			end
			ppfr_pkg::S_FLUSH: begin
				if (flush_hit) begin
					f_q      <= ch.fidx;
					empty_q  <= 1'b0;
					wb_q     <= 1'b1;
					wbpage_q <= ch.page;
					last_q   <= !ch.later;
				end else begin
					r_q <= r_q + 1'b1;
				end
			end
			ppfr_pkg::S_REPORT: begin
				if (out_free) begin
					r_q                <= r_q + 1'b1;
					rsp.status         <= st_q;
					rsp.hit            <= hit_q;
					rsp.frame          <= f_q[3:0];
					rsp.read_fill      <= fill_q;
					rsp.writeback      <= wb_q;
					rsp.writeback_page <= wb_q ? wbpage_q : '0;
					rsp.pin_count      <= rep_empty ? '0 : ch.pin;
					rsp.dirty_flag     <= rep_empty ? 1'b0 : ch.dirty;
					rsp.frame_page     <= (rep_empty || !ch.valid) ? '1 :
						signed'({1'b0, ch.page});
					rsp.last_result    <= last_q;
					rsp.read_total     <= reads_q;
					rsp.write_total    <= writes_q;
				end
			end
			default: ;
		endcase
	end

endmodule

[rtl/pinned_page_frame_replacement.sv]
// Pin hit, unpin, mark dirty, flush page and query pass through the find and report
// states; a pin miss into an empty frame adds the fill-select state; an eviction
// scans ranks tail to head, one rank per cycle. Flush all walks one rank per cycle
// while no dirty frame is found and stops to report each written-back frame. One item at a
// time; the next beat is taken the cycle after the last result is loaded.
// Reset (arst_n) and a frames_in_use write empty all frames, restore rank order, clear counters.
// ----------------------------------------------------------------------------
// pinned_page_frame_replacement
// Buffer pool frame manager with pinning and LRU or FIFO replacement.
// ----------------------------------------------------------------------------
module pinned_page_frame_replacement #(
	parameter int FRAMES = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ppfr_pkg::ADDR_W-1:0]   paddr,
	input  logic [ppfr_pkg::DATA_W-1:0]   pwdata,
	output logic [ppfr_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	ppfr_req_if.sink                      req,
	ppfr_rsp_if.source                    rsp
);
	localparam int FIU_RESET = FRAMES < 16 ? FRAMES : 16;

	logic             policy_q;
	ppfr_pkg::fcnt_t  fiu_q;
	logic             wr, init;
	logic [ppfr_pkg::FIU_W-1:0] wv;
	ppfr_pkg::fcnt_t  wsat;
	ppfr_pkg::probe_t probe;
	ppfr_pkg::cmd_t   cmd;
	ppfr_pkg::chain_t chain [FRAMES+1];

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;
	assign init   = wr && ppfr_pkg::reg_idx_t'(paddr[2]) == ppfr_pkg::REG_FRAMES;
	assign wv     = pwdata[ppfr_pkg::FIU_W-1:0];

	always_comb begin
		if (wv == '0) wsat = ppfr_pkg::fcnt_t'(1);
		else if ({2'b0, wv} > ppfr_pkg::fcnt_t'(FRAMES)) wsat = ppfr_pkg::fcnt_t'(FRAMES);
		else wsat = ppfr_pkg::fcnt_t'(wv);
	end

	always_comb begin
		case (ppfr_pkg::reg_idx_t'(paddr[2]))
			ppfr_pkg::REG_POLICY: prdata = {{(ppfr_pkg::DATA_W-1){1'b0}}, policy_q};
			ppfr_pkg::REG_FRAMES: prdata = ppfr_pkg::DATA_W'(fiu_q);
			default:              prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= ppfr_pkg::POLICY_LRU;
			fiu_q    <= ppfr_pkg::fcnt_t'(FIU_RESET);
		end else if (wr) begin
			if (ppfr_pkg::reg_idx_t'(paddr[2]) == ppfr_pkg::REG_POLICY) policy_q <= pwdata[0];
			else fiu_q <= wsat;
		end
	end

	assign chain[0] = '0;

	for (genvar i = 0; i < FRAMES; i++) begin : g_cell
		ppfr_cell #(.IDX(i)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.init    (init),
			.fiu     (fiu_q),
			.cmd     (cmd),
			.probe   (probe),
			.chain_i (chain[i]),
			.chain_o (chain[i+1])
		);
	end

	ppfr_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.init   (init),
		.policy (policy_q),
		.fiu    (fiu_q),
		.ch     (chain[FRAMES]),
		.probe  (probe),
		.cmd    (cmd),
		.req    (req),
		.rsp    (rsp)
	);

endmodule

[rtl/ppfr_checker.sv]
// ----------------------------------------------------------------------------
// ppfr_checker
// Port-level checks of the frame manager, bound to the top level.
// ----------------------------------------------------------------------------
`include "pinned_page_frame_replacement_macros.svh"

module ppfr_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        rsp_valid,
	input logic                        rsp_ready,
	input logic                        rsp_status,
	input logic                        rsp_hit,
	input logic                        rsp_read_fill,
	input logic                        rsp_writeback,
	input logic [ppfr_pkg::PAGE_W-1:0] rsp_writeback_page,
	input logic [ppfr_pkg::PIN_W-1:0]  rsp_pin_count,
	input logic signed [16:0]          rsp_frame_page
);
	`PPFR_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid)
	`PPFR_NEVER(a_full_empty, rsp_valid && rsp_status && (rsp_frame_page != -17'sd1 || rsp_pin_count != '0))
	`PPFR_NEVER(a_hit_no_io, rsp_valid && rsp_hit && (rsp_read_fill || rsp_writeback))
	`PPFR_NEVER(a_wbpage_zero, rsp_valid && !rsp_writeback && rsp_writeback_page != '0)
	`PPFR_NEVER(a_fill_pinned, rsp_valid && rsp_read_fill && rsp_pin_count != 8'd1)
endmodule

bind pinned_page_frame_replacement ppfr_checker u_ppfr_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.rsp_valid          (rsp.valid),
	.rsp_ready          (rsp.ready),
	.rsp_status         (rsp.status),
	.rsp_hit            (rsp.hit),
	.rsp_read_fill      (rsp.read_fill),
	.rsp_writeback      (rsp.writeback),
	.rsp_writeback_page (rsp.writeback_page),
	.rsp_pin_count      (rsp.pin_count),
	.rsp_frame_page     (rsp.frame_page)
);
